[hw/rtl/playfair_digraph_cipher_assert.svh]
// ---------------------------------------------------------------------------
// Playfair cipher assertion macros
// Shared concurrent assertion forms for the cipher RTL.
// ---------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/pdc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Playfair cipher package
// Letter codes, item kinds and the command and status bundles that join the
// controller and the datapath.
// ---------------------------------------------------------------------------
package pdc_pkg;

  // Letter indices, A is zero.
  localparam logic [4:0] LETTER_I    = 5'd8;
  localparam logic [4:0] LETTER_J    = 5'd9;
  localparam logic [4:0] LETTER_X    = 5'd23;
  localparam logic [4:0] LETTER_LAST = 5'd25;
  // Number of cells in the square.
  localparam logic [4:0] CELLS       = 5'd25;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_TEXT  = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    EMIT_HELD = 2'd0,
    EMIT_O1   = 2'd1,
    EMIT_MARK = 2'd2
  } emit_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      clear;
    logic      place_key;
    logic      fill_init;
    logic      fill_step;
    logic      set_pending;
    logic      cell_rd;
    logic      sq_rd;
    logic      emit_en;
    emit_sel_t emit_sel;
    logic      take_pair;
    logic      clear_held;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  letter_ok;
    logic  complete;
    logic  pending_valid;
    logic  fill_last;
    logic  held_valid;
    logic  held_send;
    logic  emit_ok;
  } status_t;

endpackage

[hw/rtl/pdc_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Playfair cipher datapath
// Holds the key square and letter positions, the pair slots, the mode
// register and the output register, and acts on controller commands.
// ---------------------------------------------------------------------------
`include "playfair_digraph_cipher_assert.svh"

module pdc_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  pdc_pkg::cmd_t    cmd,
  output pdc_pkg::status_t sts,
  input  logic [7:0]       in_tdata,   // char_code
  input  logic [1:0]       in_tuser,   // kind
  input  logic             cfg_we,
  input  logic             cfg_wdata,  // encrypt_mode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // out_char
  output logic             out_tuser,  // char_valid
  output logic             out_tlast   // end_of_message
);

  localparam logic [7:0] CODE_UA = 8'd65;
  localparam logic [7:0] CODE_UZ = 8'd90;
  localparam logic [7:0] CODE_LA = 8'd97;
  localparam logic [7:0] CODE_LZ = 8'd122;

  // Row of a cell 0..24: multiply by 13/64, exact over that range.
  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [8:0] m;
    m = {4'b0000, p} * 9'd13;
    return m[8:6];
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p, input logic [2:0] r);
    logic [4:0] d;
    d = p - ({r, 2'b00} + {2'b00, r});
    return d[2:0];
  endfunction

  function automatic logic [2:0] add_mod5(input logic [2:0] v, input logic [2:0] s);
    logic [3:0] t;
    t = {1'b0, v} + {1'b0, s};
    if (t >= 4'd5) t = t - 4'd5;
    return t[2:0];
  endfunction

  function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  // Registers.
  pdc_pkg::kind_t kind_r;
  logic [7:0]  code_r;
  logic        mode_r;
  logic [25:0] used_r;
  logic [4:0]  fill_count_r;
  logic [4:0]  fill_letter_r;
  logic        complete_r;
  logic        pending_valid_r;
  logic [4:0]  pending_l_r;
  logic        held_valid_r;
  logic [4:0]  held_l_r;
  logic [4:0]  pa_cell_r, pb_cell_r;
  logic        pa_used_r, pb_used_r;
  logic [4:0]  o1_r, o2_r;
  logic        out_valid_r;
  logic [7:0]  out_tdata_r;
  logic        out_tuser_r;
  logic        out_tlast_r;

  logic [4:0] sq_mem [25];
  logic [4:0] place_mem [26];

  logic [4:0] in_letter;
  logic       letter_ok;
  logic [7:0] code_off;
  logic [4:0] place_l;
  logic       place_en;
  logic       do_place;
  logic [4:0] b_raw, b_sel;
  logic [4:0] p1, p2;
  logic [2:0] r1, c1, r2, c2, shift;
  logic [4:0] addr1, addr2;
  logic       emit_ok;
  logic       marker_clean;

  // Fold the held character to a letter index, J read as I.
  always_comb begin
    code_off  = 8'd0;
    letter_ok = 1'b0;
    if (code_r >= CODE_UA && code_r <= CODE_UZ) begin
      code_off  = code_r - CODE_UA;
      letter_ok = 1'b1;
    end else if (code_r >= CODE_LA && code_r <= CODE_LZ) begin
      code_off  = code_r - CODE_LA;
      letter_ok = 1'b1;
    end
    in_letter = code_off[4:0];
    if (in_letter == pdc_pkg::LETTER_J) in_letter = pdc_pkg::LETTER_I;
  end

  // Input beat capture and mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= pdc_pkg::KIND_CLEAR;
      code_r <= 8'd0;
      mode_r <= 1'b1;
    end else begin
      if (cmd.load_in) begin
        kind_r <= pdc_pkg::kind_t'(in_tuser);
        code_r <= in_tdata;
      end
      if (cfg_we) mode_r <= cfg_wdata;
    end
  end

  // Letter placement, from a key character or from the fill sweep.
  always_comb begin
    place_l  = in_letter;
    place_en = 1'b0;
    if (cmd.place_key) begin
      place_en = 1'b1;
    end else if (cmd.fill_step) begin
      place_l  = fill_letter_r;
      place_en = (fill_letter_r != pdc_pkg::LETTER_J);
    end
    do_place = place_en && !used_r[place_l] && (fill_count_r < pdc_pkg::CELLS);
  end

  // Square bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r        <= '0;
      fill_count_r  <= 5'd0;
      fill_letter_r <= 5'd0;
      complete_r    <= 1'b0;
    end else if (cmd.clear) begin
      used_r       <= '0;
      fill_count_r <= 5'd0;
      complete_r   <= 1'b0;
    end else begin
      if (do_place) begin
        used_r[place_l] <= 1'b1;
        fill_count_r    <= fill_count_r + 5'd1;
      end
      if (cmd.fill_init) fill_letter_r <= 5'd0;
      else if (cmd.fill_step) fill_letter_r <= fill_letter_r + 5'd1;
      if (cmd.fill_step && fill_letter_r == pdc_pkg::LETTER_LAST) complete_r <= 1'b1;
    end
  end

  // Second letter of the pair: X at end of message, X for a doubled pair
  // when encrypting.
  always_comb begin
    b_raw = (kind_r == pdc_pkg::KIND_END) ? pdc_pkg::LETTER_X : in_letter;
    b_sel = (mode_r && pending_l_r == b_raw) ? pdc_pkg::LETTER_X : b_raw;
  end

  // Memory writes and the registered position and square reads.
  always_ff @(posedge clk) begin
    if (do_place) begin
      sq_mem[fill_count_r] <= place_l;
      place_mem[place_l]   <= fill_count_r;
    end
    if (cmd.cell_rd) begin
      pa_cell_r <= place_mem[pending_l_r];
      pb_cell_r <= place_mem[b_sel];
      pa_used_r <= used_r[pending_l_r];
      pb_used_r <= used_r[b_sel];
    end
    if (cmd.sq_rd) begin
      o1_r <= sq_mem[addr1];
      o2_r <= sq_mem[addr2];
    end
  end

  // Pair rules: same row, same column or rectangle.
  always_comb begin
    p1    = (pa_used_r && pa_cell_r < pdc_pkg::CELLS) ? pa_cell_r : 5'd0;
    p2    = (pb_used_r && pb_cell_r < pdc_pkg::CELLS) ? pb_cell_r : 5'd0;
    r1    = row_of(p1);
    r2    = row_of(p2);
    c1    = col_of(p1, r1);
    c2    = col_of(p2, r2);
    shift = mode_r ? 3'd1 : 3'd4;
    if (r1 == r2) begin
      addr1 = cell_addr(r1, add_mod5(c1, shift));
      addr2 = cell_addr(r2, add_mod5(c2, shift));
    end else if (c1 == c2) begin
      addr1 = cell_addr(add_mod5(r1, shift), c1);
      addr2 = cell_addr(add_mod5(r2, shift), c2);
    end else begin
      addr1 = cell_addr(r1, c2);
      addr2 = cell_addr(r2, c1);
    end
  end

  // Pending letter and held output letter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_valid_r <= 1'b0;
      pending_l_r     <= 5'd0;
      held_valid_r    <= 1'b0;
      held_l_r        <= 5'd0;
    end else if (cmd.clear) begin
      pending_valid_r <= 1'b0;
      held_valid_r    <= 1'b0;
    end else begin
      if (cmd.set_pending) begin
        pending_valid_r <= 1'b1;
        pending_l_r     <= in_letter;
      end
      if (cmd.take_pair) begin
        pending_valid_r <= 1'b0;
        held_valid_r    <= 1'b1;
        held_l_r        <= o2_r;
      end
      if (cmd.clear_held) held_valid_r <= 1'b0;
    end
  end

  assign emit_ok = !out_valid_r || out_tready;

  // Output register: one result beat at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      case (cmd.emit_sel)
        pdc_pkg::EMIT_HELD: begin
          out_tdata_r <= CODE_UA + {3'b000, held_l_r};
          out_tuser_r <= 1'b1;
          out_tlast_r <= 1'b0;
        end
        pdc_pkg::EMIT_O1: begin
          out_tdata_r <= CODE_UA + {3'b000, o1_r};
          out_tuser_r <= 1'b1;
          out_tlast_r <= 1'b0;
        end
        default: begin
          out_tdata_r <= 8'd0;
          out_tuser_r <= 1'b0;
          out_tlast_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // Status towards the controller.
  always_comb begin
    sts.kind          = kind_r;
    sts.letter_ok     = letter_ok;
    sts.complete      = complete_r;
    sts.pending_valid = pending_valid_r;
    sts.fill_last     = (fill_letter_r == pdc_pkg::LETTER_LAST);
    sts.held_valid    = held_valid_r;
    sts.held_send     = held_valid_r && (mode_r || held_l_r != pdc_pkg::LETTER_X);
    sts.emit_ok       = emit_ok;
  end

  // A marker beat carries no letter.
  assign marker_clean = !out_tuser_r && (out_tdata_r == 8'd0);

  // Checks.
  `PDC_ASSERT_IMPLY(a_emit_when_free, clk, rst_n, cmd.emit_en, !out_valid_r || out_tready)
  `PDC_ASSERT_IMPLY(a_full_square, clk, rst_n, complete_r, fill_count_r == pdc_pkg::CELLS)
  `PDC_ASSERT_NEXT(a_fill_completes, clk, rst_n, cmd.fill_step && sts.fill_last, complete_r)
  `PDC_ASSERT_IMPLY(a_marker_empty, clk, rst_n, out_valid_r && out_tlast_r, marker_clean)

endmodule

[hw/rtl/pdc_controller.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Playfair cipher controller
// Sequences each input item: dispatch, square fill sweep, pair lookup and
// the result beats.
// ---------------------------------------------------------------------------
module pdc_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  pdc_pkg::status_t sts,
  output pdc_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_FILL     = 8'b0000_0100,
    S_CELL     = 8'b0000_1000,
    S_SQR      = 8'b0001_0000,
    S_EHELD    = 8'b0010_0000,
    S_EO1      = 8'b0100_0000,
    S_ETAIL    = 8'b1000_0000
  } state_t;

  state_t st_r, st_nxt;
  logic   mark_r, mark_nxt;

  assign in_tready = (st_r == S_IDLE) && !mark_r;

  // Next state and commands.
  always_comb begin
    st_nxt       = st_r;
    mark_nxt     = mark_r;
    cmd          = '0;
    cmd.emit_sel = pdc_pkg::EMIT_HELD;
    case (st_r)
      S_IDLE: begin
        if (mark_r) begin
          // The end-of-message marker waits here for the output register.
          if (sts.emit_ok) begin
            cmd.emit_en  = 1'b1;
            cmd.emit_sel = pdc_pkg::EMIT_MARK;
            mark_nxt     = 1'b0;
          end
        end else if (in_tvalid) begin
          cmd.load_in = 1'b1;
          st_nxt      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        st_nxt = S_IDLE;
        case (sts.kind)
          pdc_pkg::KIND_CLEAR: cmd.clear = 1'b1;
          pdc_pkg::KIND_KEY: begin
            if (sts.letter_ok && !sts.complete) cmd.place_key = 1'b1;
          end
          pdc_pkg::KIND_TEXT: begin
            if (sts.letter_ok) begin
              if (!sts.complete) begin
                cmd.fill_init = 1'b1;
                st_nxt        = S_FILL;
              end else if (sts.pending_valid) begin
                st_nxt = S_CELL;
              end else begin
                cmd.set_pending = 1'b1;
              end
            end
          end
          default: st_nxt = sts.pending_valid ? S_CELL : S_ETAIL;
        endcase
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) st_nxt = S_DISPATCH;
      end
      S_CELL: begin
        cmd.cell_rd = 1'b1;
        st_nxt      = S_SQR;
      end
      S_SQR: begin
        cmd.sq_rd = 1'b1;
        st_nxt    = S_EHELD;
      end
      S_EHELD: begin
        if (!sts.held_valid) begin
          st_nxt = S_EO1;
        end else if (sts.emit_ok) begin
          cmd.emit_en = 1'b1;
          st_nxt      = S_EO1;
        end
      end
      S_EO1: begin
        if (sts.emit_ok) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_sel  = pdc_pkg::EMIT_O1;
          cmd.take_pair = 1'b1;
          st_nxt        = (sts.kind == pdc_pkg::KIND_END) ? S_ETAIL : S_IDLE;
        end
      end
      S_ETAIL: begin
        // Last held letter, dropped when it is a final X in decrypt mode.
        if (!sts.held_send) begin
          cmd.clear_held = 1'b1;
          mark_nxt       = 1'b1;
          st_nxt         = S_IDLE;
        end else if (sts.emit_ok) begin
          cmd.emit_en    = 1'b1;
          cmd.clear_held = 1'b1;
          mark_nxt       = 1'b1;
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt   = S_IDLE;
        mark_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      mark_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      mark_r <= mark_nxt;
    end
  end

endmodule

[hw/rtl/playfair_digraph_cipher.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Playfair digraph cipher
// Streaming Playfair encrypt and decrypt over ASCII characters.
// ---------------------------------------------------------------------------
// Each input beat carries a kind in in_tuser and an ASCII byte in in_tdata;
// results come out one beat at a time, a capital letter in out_tdata with
// out_tuser set, or the end-of-message marker with out_tlast set. The first
// text letter after a clear or reset adds a sweep that completes the square
// and a second dispatch. A completed pair gives up to 2 result beats, and an
// end of message up to 4 when it pads an odd letter; the pair lookup goes
// through the registered reads of the position and square memories, and the
// single output register sends each result beat in a cycle of its own; a
// stalled out_tready holds the sequence. The user must write encrypt_mode
// through cfg_we and cfg_wdata only while no item is in progress; the block
// itself does not enforce this.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // char_code
  input  logic [1:0] in_tuser,   // kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_char
  output logic       out_tuser,  // char_valid
  output logic       out_tlast,  // end_of_message
  input  logic       cfg_we,
  input  logic       cfg_wdata   // encrypt_mode
);

  pdc_pkg::cmd_t    cmd;
  pdc_pkg::status_t sts;

  // Sequencing.
  pdc_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and cipher logic.
  pdc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/sv/playfair_digraph_cipher_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Playfair digraph cipher checker
// Watches the input, output and configuration ports of the cipher, predicts
// the result beats of every accepted input beat and compares each accepted
// output beat, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // char_code
  input  logic [1:0] in_tuser,   // kind
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // out_char
  input  logic       out_tuser,  // char_valid
  input  logic       out_tlast,  // end_of_message
  input  logic       cfg_we,
  input  logic       cfg_wdata,  // encrypt_mode
  output int         mismatches,
  output int         awaited
);

  typedef struct packed {
    logic [7:0] code;
    logic       is_letter;
    logic       closes;
  } cipher_beat_t;

  cipher_beat_t cipher_q[$];

  // Shadow copy of the key square and the message state.
  logic [4:0] square_at [25];
  logic [6:0] place_of [26];
  logic [4:0] filled;
  bit         complete;
  bit         encrypting;
  logic [5:0] first_letter;
  logic [5:0] held_letter;

  task automatic clear_square();
    for (int i = 0; i < 25; i++) square_at[i] = '0;
    for (int i = 0; i < 26; i++) place_of[i] = '0;
    filled       = '0;
    complete     = 1'b0;
    first_letter = '0;
    held_letter  = '0;
  endtask

  // Letter index with J folded onto I, or -1 for anything that is not a letter.
  function automatic int fold(input logic [7:0] code);
    int v;
    if (code >= 8'h41 && code <= 8'h5A) v = int'(code) - 8'h41;
    else if (code >= 8'h61 && code <= 8'h7A) v = int'(code) - 8'h61;
    else return -1;
    if (v == int'(pdc_pkg::LETTER_J)) v = int'(pdc_pkg::LETTER_I);
    return v;
  endfunction

  task automatic add_letter(input int l);
    if (!place_of[l][6] && filled < pdc_pkg::CELLS) begin
      square_at[filled] = 5'(l);
      place_of[l]       = {2'b10, filled};
      filled++;
    end
  endtask

  function automatic int cell_of(input logic [4:0] l);
    logic [4:0] p;
    p = place_of[l][4:0];
    return (p < pdc_pkg::CELLS) ? int'(p) : 0;
  endfunction

  // Same row and same column shift by one when encrypting and by four
  // when decrypting; otherwise the corners of the rectangle are swapped.
  task automatic cipher_pair(input logic [4:0] a, input logic [4:0] b_in,
                             output logic [4:0] o1, output logic [4:0] o2);
    int s, p1, p2, r1, c1, r2, c2;
    logic [4:0] b;
    b = b_in;
    s = encrypting ? 1 : 4;
    if (encrypting && a == b) b = pdc_pkg::LETTER_X;
    p1 = cell_of(a);
    p2 = cell_of(b);
    r1 = p1 / 5;
    c1 = p1 % 5;
    r2 = p2 / 5;
    c2 = p2 % 5;
    if (r1 == r2) begin
      o1 = square_at[r1 * 5 + (c1 + s) % 5];
      o2 = square_at[r2 * 5 + (c2 + s) % 5];
    end else if (c1 == c2) begin
      o1 = square_at[((r1 + s) % 5) * 5 + c1];
      o2 = square_at[((r2 + s) % 5) * 5 + c2];
    end else begin
      o1 = square_at[r1 * 5 + c2];
      o2 = square_at[r2 * 5 + c1];
    end
  endtask

  task automatic expect_beat(input logic [4:0] l, input bit letter, input bit closes);
    cipher_beat_t b;
    b.code      = letter ? 8'h41 + 8'(l) : 8'h00;
    b.is_letter = letter;
    b.closes    = closes;
    cipher_q.push_back(b);
  endtask

  // The held letter goes out first, then the first letter of the new pair;
  // the second letter is held back.
  task automatic cipher_and_queue(input logic [4:0] a, input logic [4:0] b);
    logic [4:0] o1, o2;
    cipher_pair(a, b, o1, o2);
    if (held_letter[5]) expect_beat(held_letter[4:0], 1'b1, 1'b0);
    expect_beat(o1, 1'b1, 1'b0);
    held_letter = {1'b1, o2};
  endtask

  task automatic predict(input pdc_pkg::kind_t kind, input logic [7:0] code);
    int l;
    l = fold(code);
    case (kind)
      pdc_pkg::KIND_CLEAR: begin
        clear_square();
      end
      pdc_pkg::KIND_KEY: begin
        if (l >= 0 && !complete) add_letter(l);
      end
      pdc_pkg::KIND_TEXT: begin
        if (l >= 0) begin
          // The first text letter completes the square with the unused letters.
          if (!complete) begin
            for (int c = 0; c < 26; c++) begin
              if (c != int'(pdc_pkg::LETTER_J)) add_letter(c);
            end
            complete = 1'b1;
          end
          if (first_letter[5]) begin
            cipher_and_queue(first_letter[4:0], 5'(l));
            first_letter = '0;
          end else begin
            first_letter = {1'b1, 5'(l)};
          end
        end
      end
      default: begin
        // End of message: pad an odd letter, flush the held one, then mark.
        if (first_letter[5]) begin
          cipher_and_queue(first_letter[4:0], pdc_pkg::LETTER_X);
          first_letter = '0;
        end
        if (held_letter[5] && (encrypting || held_letter[4:0] != pdc_pkg::LETTER_X)) begin
          expect_beat(held_letter[4:0], 1'b1, 1'b0);
        end
        held_letter = '0;
        expect_beat(5'd0, 1'b0, 1'b1);
      end
    endcase
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_beat();
    cipher_beat_t want;
    if (cipher_q.size() == 0) begin
      report("output beat with nothing expected", out_tdata, 8'h00);
    end else begin
      want = cipher_q.pop_front();
      if (out_tdata !== want.code) report("out_char", out_tdata, want.code);
      if (out_tuser !== want.is_letter) report("char_valid", 8'(out_tuser), 8'(want.is_letter));
      if (out_tlast !== want.closes) report("end_of_message", 8'(out_tlast), 8'(want.closes));
    end
  endtask

  // Output beats are checked before the input beat of the same edge is
  // predicted, so a result can never be matched against its own input.
  always @(posedge clk) begin
    if (!rst_n) begin
      encrypting = 1'b1;
      clear_square();
      cipher_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) encrypting = cfg_wdata;
      if (out_tvalid && out_tready) compare_beat();
      if (in_tvalid && in_tready) predict(pdc_pkg::kind_t'(in_tuser), in_tdata);
    end
    awaited <= cipher_q.size();
  end

endmodule

[tb/sv/tb_playfair_digraph_cipher.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Playfair digraph cipher testbench
// Drives a directed set of keys and messages and then random messages in
// both modes through the cipher, with random gaps and stalls on both sides,
// and reports the verdict of the checker.
// ---------------------------------------------------------------------------
module tb_playfair_digraph_cipher;

  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = 48;
  localparam int STALL_CYCLES   = 160;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEM_TARGET    = 500;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // char_code
  logic [1:0] in_tuser;   // kind
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // out_char
  logic       out_tuser;  // char_valid
  logic       out_tlast;  // end_of_message
  logic       cfg_we;
  logic       cfg_wdata;  // encrypt_mode

  int mismatches;
  int awaited;
  int items_sent;
  int quiet_cycles;
  bit calm;
  bit long_hold;
  bit hold_done;

  always #6 clk = ~clk;

  playfair_digraph_cipher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  playfair_digraph_cipher_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // Receiver: short random stalls, one long hold-off on request, none when calm.
  initial begin
    out_tready = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // The run ends if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("playfair_digraph_cipher: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input pdc_pkg::kind_t kind, input logic [7:0] code);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  // The mode is changed only once the cipher has gone quiet.
  task automatic write_mode(input bit encrypting);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= encrypting;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A letter in either case, with J and X picked more often than the rest.
  function automatic logic [7:0] pick_letter();
    int v;
    v = $urandom_range(0, 25);
    case ($urandom_range(0, 7))
      0: v = int'(pdc_pkg::LETTER_J);
      1: v = int'(pdc_pkg::LETTER_X);
      default: ;
    endcase
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v);
  endfunction

  // One message: an optional new key, text with doubled letters, stray
  // bytes and late key characters mixed in, then the end marker.
  task automatic random_message();
    int keys, count;
    logic [7:0] prev;
    prev = pick_letter();
    if ($urandom_range(0, 2) == 0) begin
      send_beat(pdc_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)));
      keys = $urandom_range(0, 14);
      repeat (keys) begin
        send_beat(pdc_pkg::KIND_KEY,
                  $urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 255)) : pick_letter());
      end
    end
    count = $urandom_range(0, 16);
    repeat (count) begin
      case ($urandom_range(0, 15))
        0: send_beat(pdc_pkg::kind_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
        1: send_beat(pdc_pkg::KIND_KEY, pick_letter());
        2, 3, 4: send_beat(pdc_pkg::KIND_TEXT, prev);
        default: begin
          prev = pick_letter();
          send_beat(pdc_pkg::KIND_TEXT, prev);
        end
      endcase
    end
    send_beat(pdc_pkg::KIND_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int phase;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = 1'b0;
    calm       = 1'b0;
    long_hold  = 1'b0;
    items_sent = 0;
    phase      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message straight after reset: only the end marker comes out.
    send_beat(pdc_pkg::KIND_END, 8'h00);
    // Key with lower case, J folded onto I, a repeat and non-letters.
    send_beat(pdc_pkg::KIND_KEY, "p");
    send_beat(pdc_pkg::KIND_KEY, "j");
    send_beat(pdc_pkg::KIND_KEY, "J");
    send_beat(pdc_pkg::KIND_KEY, "1");
    send_beat(pdc_pkg::KIND_KEY, 8'hFF);
    // Doubled pair, ignored byte, key after text, J in text, odd tail.
    send_beat(pdc_pkg::KIND_TEXT, "a");
    send_beat(pdc_pkg::KIND_TEXT, "a");
    send_beat(pdc_pkg::KIND_TEXT, 8'h00);
    send_beat(pdc_pkg::KIND_KEY, "Z");
    send_beat(pdc_pkg::KIND_TEXT, "j");
    send_beat(pdc_pkg::KIND_TEXT, "z");
    send_beat(pdc_pkg::KIND_TEXT, "q");
    send_beat(pdc_pkg::KIND_END, 8'h20);
    // Plain alphabetic square: same-row pair, then same-column pair.
    send_beat(pdc_pkg::KIND_CLEAR, 8'hAA);
    send_beat(pdc_pkg::KIND_TEXT, "A");
    send_beat(pdc_pkg::KIND_TEXT, "B");
    send_beat(pdc_pkg::KIND_TEXT, "A");
    send_beat(pdc_pkg::KIND_TEXT, "F");
    send_beat(pdc_pkg::KIND_END, 8'h55);
    // Decrypt: CV deciphers to AX and the final X is dropped; then an odd tail.
    write_mode(1'b0);
    send_beat(pdc_pkg::KIND_TEXT, "C");
    send_beat(pdc_pkg::KIND_TEXT, "V");
    send_beat(pdc_pkg::KIND_END, 8'h00);
    send_beat(pdc_pkg::KIND_TEXT, "Q");
    send_beat(pdc_pkg::KIND_END, 8'h00);

    // Random phases, alternating the mode between them.
    while (items_sent < ITEM_TARGET) begin
      write_mode(phase % 2 == 0);
      if (phase == 1) long_hold = 1'b1;
      if (items_sent >= ITEM_TARGET - 100) calm = 1'b1;
      repeat (6) random_message();
      // The sender waits once for every result before going on.
      if (phase == 2) hold_until_drained();
      phase++;
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("playfair_digraph_cipher: match");
    end else begin
      $display("playfair_digraph_cipher: mismatch");
    end
    $finish;
  end

endmodule
